### hw/rtl/qab_pkg.sv
// Shared types, widths and constants for the Bretschneider quadrilateral area core.
// Holds the CORDIC angle table and the cell state structs; depends on nothing.
package qab_pkg;

  localparam int SIDE_W = 24;
  localparam int ANG_W = 16;
  localparam int AREA_W = 40;

  localparam int PSUM_W = 27;
  localparam int MAG_W = 26;
  localparam int PP1_W = 52;
  localparam int AB_W = 48;
  localparam int P_W = 104;
  localparam int A_W = 96;
  localparam int C2_W = 31;
  localparam int PPC_W = 63;
  localparam int ACS_W = 127;
  localparam int TERM_W = 101;
  localparam int REM_W = 84;
  localparam int ROOT_W = 42;

  localparam int XY_W = 34;
  localparam int Z_W = 30;
  localparam int CORDIC_STEPS = 24;

  localparam logic [ANG_W-1:0] FULL_TURN = 16'd46080;
  localparam logic [ANG_W-1:0] HALF_TURN = 16'd23040;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 16'd11520;

  localparam logic signed [XY_W-1:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Rounded atan(2^-i) in units of 2^-20 degree.
  localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd47185920, 30'd27855475, 30'd14718068, 30'd7471121, 30'd3750058, 30'd1876857,
    30'd938658, 30'd469357, 30'd234682, 30'd117342, 30'd58671, 30'd29335,
    30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458,
    30'd229, 30'd115, 30'd57, 30'd29, 30'd14, 30'd7
  };

  // State handed from one CORDIC cell to the next.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic neg;
  } cordic_t;

  // State handed from one square root cell to the next.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic ok;
  } sqrt_t;

endpackage

### hw/rtl/qab_cordic_cell.sv
// One rotation step of the cosine CORDIC chain.
// Depends on qab_pkg for the state struct and the angle table.
module qab_cordic_cell
  import qab_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t d_in,
  output cordic_t d_out
);

  cordic_t cell_r, cell_nxt;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0] da;

  // Arithmetic shifts round toward minus infinity.
  assign dx = d_in.y >>> STEP;
  assign dy = d_in.x >>> STEP;
  assign da = signed'(ATAN_TAB[STEP]);

  // Rotate toward zero residual angle.
  always_comb begin
    cell_nxt = d_in;
    if (!d_in.z[Z_W-1]) begin
      cell_nxt.x = d_in.x - dx;
      cell_nxt.y = d_in.y + dy;
      cell_nxt.z = d_in.z - da;
    end else begin
      cell_nxt.x = d_in.x + dx;
      cell_nxt.y = d_in.y - dy;
      cell_nxt.z = d_in.z + da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

### hw/rtl/qab_sqrt_cell.sv
// One bit of the restoring integer square root chain.
// Depends on qab_pkg for the state struct and widths.
module qab_sqrt_cell
  import qab_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t d_in,
  output sqrt_t d_out
);

  sqrt_t cell_r, cell_nxt;
  logic [REM_W-1:0] trial;
  logic ge;

  // Trial term 2*root*2^BIT + 2^(2*BIT); root has no bits at or below BIT yet.
  assign trial = (REM_W'(d_in.root) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));
  assign ge = (d_in.rem >= trial);

  always_comb begin
    cell_nxt = d_in;
    if (ge) begin
      cell_nxt.rem = d_in.rem - trial;
      cell_nxt.root = d_in.root | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

### hw/rtl/quadrilateral_area_bretschneider_core.sv
// Top level of the Bretschneider quadrilateral area core: products, CORDIC and sqrt chains.
// Depends on qab_pkg, qab_cordic_cell and qab_sqrt_cell.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   in       | in_valid / in_stall  | in_side_a..in_side_d, in_angle_sum
//   out      | out_valid / out_stall| out_area, out_valid_res
//
// One request is taken every cycle while in_stall is low; a result passes through the product
// stages, the 24 CORDIC cells and the 42 square root cells before reaching the output registers.
// Reset (rst_n low, synchronous) empties the pipeline and the output registers.
// A stalled result waits in the output register; the next one lands in a skid
// register, and only while that is full is in_stall raised and the pipeline frozen.
module quadrilateral_area_bretschneider_core
  import qab_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SIDE_W-1:0] in_side_a,
  input  logic [SIDE_W-1:0] in_side_b,
  input  logic [SIDE_W-1:0] in_side_c,
  input  logic [SIDE_W-1:0] in_side_d,
  input  logic [ANG_W-1:0]  in_angle_sum,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [AREA_W-1:0] out_area,
  output logic              out_valid_res
);

  localparam int NSTG = 30 + ROOT_W;
  localparam int DLY_N = 21;
  localparam int DLY_W = 1 + P_W + A_W;

  logic en, in_acc;
  logic out_v_r, sk_v_r, take;
  logic [NSTG-1:0] vld_r;

  assign en = !sk_v_r;
  assign in_acc = in_valid && !in_stall;

  // Valid bit per stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_acc};
    end
  end

  // Input register.
  logic [SIDE_W-1:0] side_r [4];
  logic [ANG_W-1:0] ang_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side_a;
      side_r[1] <= in_side_b;
      side_r[2] <= in_side_c;
      side_r[3] <= in_side_d;
      ang_r <= in_angle_sum;
    end
  end

  // Twice (s - x) for each side, its magnitude and the sign parity.
  logic [PSUM_W-1:0] tot, pv [4];
  logic [MAG_W-1:0] mg [4];
  logic par;

  always_comb begin
    tot = PSUM_W'(side_r[0]) + PSUM_W'(side_r[1]) + PSUM_W'(side_r[2])
        + PSUM_W'(side_r[3]);
    par = 1'b0;
    for (int i = 0; i < 4; i++) begin
      pv[i] = tot - PSUM_W'(side_r[i]) - PSUM_W'(side_r[i]);
      mg[i] = pv[i][PSUM_W-1] ? MAG_W'(-pv[i]) : pv[i][MAG_W-1:0];
      par = par ^ pv[i][PSUM_W-1];
    end
  end

  // Fold the angle into a quarter turn.
  logic [ANG_W-1:0] t0, t1, t2;
  logic neg;

  always_comb begin
    t0 = (ang_r >= FULL_TURN) ? ang_r - FULL_TURN : ang_r;
    t1 = (t0 > HALF_TURN) ? FULL_TURN - t0 : t0;
    neg = (t1 > QUARTER_TURN);
    t2 = neg ? HALF_TURN - t1 : t1;
  end

  logic [MAG_W-1:0] mg_r [4];
  logic [SIDE_W-1:0] side2_r [4];
  logic par2_r, neg2_r;
  logic signed [Z_W-1:0] z0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mg_r <= mg;
      side2_r <= side_r;
      par2_r <= par;
      neg2_r <= neg;
      z0_r <= signed'(Z_W'({t2, 13'b0}));
    end
  end

  // First products.
  logic [PP1_W-1:0] x3_r, y3_r;
  logic [AB_W-1:0] ab3_r, cd3_r;
  logic par3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x3_r <= PP1_W'(mg_r[0]) * PP1_W'(mg_r[1]);
      y3_r <= PP1_W'(mg_r[2]) * PP1_W'(mg_r[3]);
      ab3_r <= AB_W'(side2_r[0]) * AB_W'(side2_r[1]);
      cd3_r <= AB_W'(side2_r[2]) * AB_W'(side2_r[3]);
      par3_r <= par2_r;
    end
  end

  // Partial products of the wide multiplies.
  logic [PP1_W-1:0] pll_r, plh_r, phl_r, phh_r;
  logic [AB_W-1:0] all_r, alh_r, ahl_r, ahh_r;
  logic par4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r <= PP1_W'(x3_r[25:0]) * PP1_W'(y3_r[25:0]);
      plh_r <= PP1_W'(x3_r[25:0]) * PP1_W'(y3_r[51:26]);
      phl_r <= PP1_W'(x3_r[51:26]) * PP1_W'(y3_r[25:0]);
      phh_r <= PP1_W'(x3_r[51:26]) * PP1_W'(y3_r[51:26]);
      all_r <= AB_W'(ab3_r[23:0]) * AB_W'(cd3_r[23:0]);
      alh_r <= AB_W'(ab3_r[23:0]) * AB_W'(cd3_r[47:24]);
      ahl_r <= AB_W'(ab3_r[47:24]) * AB_W'(cd3_r[23:0]);
      ahh_r <= AB_W'(ab3_r[47:24]) * AB_W'(cd3_r[47:24]);
      par4_r <= par3_r;
    end
  end

  // Full products P and A.
  logic [P_W-1:0] p5_r;
  logic [A_W-1:0] a5_r;
  logic par5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_r <= (P_W'(phh_r) << 52) + ((P_W'(plh_r) + P_W'(phl_r)) << 26) + P_W'(pll_r);
      a5_r <= (A_W'(ahh_r) << 48) + ((A_W'(alh_r) + A_W'(ahl_r)) << 24) + A_W'(all_r);
      par5_r <= par4_r;
    end
  end

  // Hold the products until the cosine is ready.
  logic [DLY_W-1:0] dly_r [DLY_N];

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= {par5_r, p5_r, a5_r};
      for (int i = 1; i < DLY_N; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  // CORDIC chain.
  cordic_t cord_s [CORDIC_STEPS+1];

  assign cord_s[0] = '{x: CORDIC_GAIN, y: '0, z: z0_r, neg: neg2_r};

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    qab_cordic_cell #(.STEP(g)) u_cell (
      .clk   (clk),
      .en    (en),
      .d_in  (cord_s[g]),
      .d_out (cord_s[g+1])
    );
  end

  // Squared half-angle cosine from the clamped cosine.
  logic signed [XY_W-1:0] xc, cs, csum;

  always_comb begin
    if (cord_s[CORDIC_STEPS].x > ONE_Q30) begin
      xc = ONE_Q30;
    end else if (cord_s[CORDIC_STEPS].x < 0) begin
      xc = '0;
    end else begin
      xc = cord_s[CORDIC_STEPS].x;
    end
    cs = cord_s[CORDIC_STEPS].neg ? -xc : xc;
    csum = ONE_Q30 + cs;
  end

  logic [C2_W-1:0] c2_r;
  logic [P_W-1:0] p27_r;
  logic [A_W-1:0] a27_r;
  logic par27_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r <= C2_W'(csum >>> 1);
      {par27_r, p27_r, a27_r} <= dly_r[DLY_N-1];
    end
  end

  // A times the squared cosine, in three slices.
  logic [PPC_W-1:0] pc_r [3];
  logic [P_W-1:0] p28_r;
  logic par28_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pc_r[k] <= PPC_W'(a27_r[32*k +: 32]) * PPC_W'(c2_r);
      end
      p28_r <= p27_r;
      par28_r <= par27_r;
    end
  end

  logic [ACS_W-1:0] acs;
  logic [TERM_W-1:0] term_r;
  logic [P_W-1:0] p29_r;
  logic par29_r;

  assign acs = ACS_W'(pc_r[0]) + (ACS_W'(pc_r[1]) << 32) + (ACS_W'(pc_r[2]) << 64);

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= acs[ACS_W-1:26];
      p29_r <= p28_r;
      par29_r <= par28_r;
    end
  end

  // Radicand check and the scaled radicand for the root.
  logic [P_W-1:0] diff;
  logic bad;
  logic [REM_W-1:0] m_r;
  logic ok_r;

  assign diff = p29_r - P_W'(term_r);
  assign bad = ((p29_r != '0) && par29_r) || (p29_r < P_W'(term_r));

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= diff[P_W-1:20];
      ok_r <= !bad;
    end
  end

  // Square root chain, one result bit per cell from the top.
  sqrt_t sq_s [ROOT_W+1];

  assign sq_s[0] = '{rem: m_r, root: '0, ok: ok_r};

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    qab_sqrt_cell #(.BIT(ROOT_W - 1 - g)) u_cell (
      .clk   (clk),
      .en    (en),
      .d_in  (sq_s[g]),
      .d_out (sq_s[g+1])
    );
  end

  // Final area with saturation.
  logic [AREA_W-1:0] area_t;
  logic ok_t;

  always_comb begin
    ok_t = sq_s[ROOT_W].ok;
    if (!ok_t) begin
      area_t = '0;
    end else if (sq_s[ROOT_W].root[ROOT_W-1:AREA_W] != '0) begin
      area_t = '1;
    end else begin
      area_t = sq_s[ROOT_W].root[AREA_W-1:0];
    end
  end

  // Output register and skid register.
  logic [AREA_W-1:0] out_area_r, sk_area_r;
  logic out_res_r, sk_res_r;

  assign take = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r <= 1'b0;
    end else if (sk_v_r) begin
      if (take) begin
        sk_v_r <= 1'b0;
      end
    end else if (vld_r[NSTG-1]) begin
      if (!out_v_r || take) begin
        out_v_r <= 1'b1;
      end else begin
        sk_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r) begin
      if (take) begin
        out_area_r <= sk_area_r;
        out_res_r <= sk_res_r;
      end
    end else if (vld_r[NSTG-1]) begin
      if (!out_v_r || take) begin
        out_area_r <= area_t;
        out_res_r <= ok_t;
      end else begin
        sk_area_r <= area_t;
        sk_res_r <= ok_t;
      end
    end
  end

  assign in_stall = sk_v_r;
  assign out_valid = out_v_r;
  assign out_area = out_area_r;
  assign out_valid_res = out_res_r;

endmodule
